>>> hdl/blc_pkg.sv
// ----------------------------------------------------------------------------
// blc_pkg
// Types, beat layouts and byte mapping functions of the byte level text codec.
// ----------------------------------------------------------------------------
`default_nettype none

package blc_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_type;

   // one queued job: one or two result bytes
   typedef struct packed {
      logic       two;
      logic [7:0] b0;
      logic [7:0] b1;
   } op_type;

   localparam logic       DIR_ENCODE = 1'b0;
   localparam logic       DIR_DECODE = 1'b1;
   localparam logic [7:0] UTF_LEAD2  = 8'hC0;
   localparam logic [7:0] UTF_CONT   = 8'h80;
   localparam logic [7:0] UTF_MASK6  = 8'h3F;

   function automatic logic [8:0] map_byte(input logic [7:0] b);
      logic [8:0] cp;
      if (b <= 8'd32) begin
         cp = 9'd256 + {1'b0, b};
      end else if (b <= 8'd126) begin
         cp = {1'b0, b};
      end else if (b <= 8'd160) begin
         cp = {1'b0, b} + 9'd162;
      end else if (b == 8'd173) begin
         cp = 9'd323;
      end else begin
         cp = {1'b0, b};
      end
      return cp;
   endfunction

   function automatic logic unmap_hit(input logic [20:0] cp);
      return (cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'd161 && cp <= 21'd172) ||
             (cp >= 21'd174 && cp <= 21'd323);
   endfunction

   function automatic logic [7:0] unmap_byte(input logic [20:0] cp);
      logic [7:0] b;
      if (cp <= 21'd255) begin
         b = cp[7:0];
      end else if (cp <= 21'd288) begin
         b = cp[7:0];
      end else if (cp <= 21'd322) begin
         b = 8'(cp[8:0] - 9'd162);
      end else begin
         b = 8'd173;
      end
      return b;
   endfunction

endpackage

`default_nettype wire

>>> hdl/byte_level_text_codec.sv
// ----------------------------------------------------------------------------
// byte_level_text_codec
// Byte map plus UTF-8 encode, or UTF-8 assembly plus inverse map, per direction.
// ----------------------------------------------------------------------------
//  channel  ports                      beat
//  req      push, full, req_data       one input byte and end of text flag
//  rsp      empty, pop, rsp_data       one output byte and run_last flag
//  csr      csr_we, csr_wdata          direction, 0 encode, 1 decode
//
//  A two-byte encode leaves as a lead beat and then a continuation beat; the
//  single output register emits one beat a cycle unless a stalled pop holds it.
//  The first result is registered in the job queue, then in the output register.
//  Reset clears direction, decoder state, queue and the output valid flag.
//  A stalled output fills the job queue (DEPTH jobs) before full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_level_text_codec #(
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire blc_pkg::req_type req_data,
   output logic                  empty,
   input  wire logic             pop,
   output blc_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_wdata
);

   logic            direction_ff;
   logic            accept;
   logic            job_valid;
   blc_pkg::op_type job_in;
   blc_pkg::op_type job_out;
   logic            job_empty;
   logic            job_pop;

   assign accept = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= blc_pkg::DIR_ENCODE;
      end else if (csr_we) begin
         direction_ff <= csr_wdata;
      end
   end

   blc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .direction (direction_ff),
      .accept    (accept),
      .req       (req_data),
      .job_valid (job_valid),
      .job       (job_in)
   );

   blc_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_valid),
      .wr_data (job_in),
      .full    (full),
      .rd_en   (job_pop),
      .rd_data (job_out),
      .empty   (job_empty)
   );

   blc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_out),
      .job_pop   (job_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp_data)
   );

endmodule

`default_nettype wire

>>> hdl/blc_queue.sv
// ----------------------------------------------------------------------------
// blc_queue
// Short job queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
`default_nettype none

module blc_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            wr_en,
   input  wire blc_pkg::op_type wr_data,
   output logic                 full,
   input  wire logic            rd_en,
   output blc_pkg::op_type      rd_data,
   output logic                 empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   blc_pkg::op_type slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

>>> hdl/blc_front.sv
// ----------------------------------------------------------------------------
// blc_front
// Takes input beats, runs the byte map or the UTF-8 assembler, queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module blc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             direction,
   input  wire logic             accept,
   input  wire blc_pkg::req_type req,
   output logic                  job_valid,
   output blc_pkg::op_type       job
);

   logic [20:0] acc_ff, acc_in;
   logic [1:0]  left_ff, left_in;
   logic        halt_ff, halt_in;
   logic [7:0]  c;
   logic [8:0]  cp;
   logic        done;

   assign c  = req.in_byte;
   assign cp = blc_pkg::map_byte(c);

   always_comb begin
      acc_in    = acc_ff;
      left_in   = left_ff;
      halt_in   = halt_ff;
      done      = 1'b0;
      job_valid = 1'b0;
      job.two   = 1'b0;
      job.b0    = c;
      job.b1    = 8'(cp[5:0]) | blc_pkg::UTF_CONT;
      if (accept && direction == blc_pkg::DIR_ENCODE) begin
         job_valid = 1'b1;
         if (cp >= 9'h080) begin
            job.two = 1'b1;
            job.b0  = 8'(cp[8:6]) | blc_pkg::UTF_LEAD2;
         end else begin
            job.b0 = cp[7:0];
         end
      end else if (accept && !halt_ff) begin
         if (left_ff == 2'd0) begin
            if (!c[7]) begin
               acc_in = 21'(c);
               done   = 1'b1;
            end else if (c[7:5] == 3'b110) begin
               acc_in  = 21'(c[4:0]);
               left_in = 2'd1;
            end else if (c[7:4] == 4'b1110) begin
               acc_in  = 21'(c[3:0]);
               left_in = 2'd2;
            end else if (c[7:3] == 5'b11110) begin
               acc_in  = 21'(c[2:0]);
               left_in = 2'd3;
            end else begin
               halt_in = 1'b1;
               acc_in  = '0;
            end
         end else if (c[7:6] != 2'b10) begin
            halt_in = 1'b1;
            acc_in  = '0;
            left_in = 2'd0;
         end else begin
            acc_in  = {acc_ff[14:0], c[5:0]};
            left_in = left_ff - 2'd1;
            done    = (left_ff == 2'd1);
         end
         if (done) begin
            job_valid = blc_pkg::unmap_hit(acc_in);
            job.b0    = blc_pkg::unmap_byte(acc_in);
            acc_in    = '0;
         end
      end
      if (accept && req.end_of_text) begin
         acc_in  = '0;
         left_in = 2'd0;
         halt_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         left_ff <= 2'd0;
         halt_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         left_ff <= left_in;
         halt_ff <= halt_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/blc_back.sv
// ----------------------------------------------------------------------------
// blc_back
// Drains queued jobs into result beats through a one-beat output register.
// ----------------------------------------------------------------------------
`default_nettype none

module blc_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            job_empty,
   input  wire blc_pkg::op_type job,
   output logic                 job_pop,
   output logic                 empty,
   input  wire logic            pop,
   output blc_pkg::rsp_type     rsp
);

   logic             valid_ff, valid_in;
   logic             phase_ff, phase_in;
   blc_pkg::rsp_type rsp_ff, rsp_in;
   logic             load;

   assign empty = !valid_ff;
   assign rsp   = rsp_ff;
   assign load  = (!valid_ff || pop) && !job_empty;

   always_comb begin
      valid_in = valid_ff && !pop;
      phase_in = phase_ff;
      rsp_in   = rsp_ff;
      job_pop  = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (job.two && !phase_ff) begin
            rsp_in.out_byte = job.b0;
            rsp_in.run_last = 1'b0;
            phase_in        = 1'b1;
         end else begin
            rsp_in.out_byte = job.two ? job.b1 : job.b0;
            rsp_in.run_last = 1'b1;
            phase_in        = 1'b0;
            job_pop         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

>>> hdl/blc_checker.sv
// ----------------------------------------------------------------------------
// blc_checker
// Port level checks of the byte level text codec, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module blc_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             empty,
   input wire logic             pop,
   input wire blc_pkg::rsp_type rsp_data
);

   // no result present right after reset
   a_reset_empty : assert property (@(posedge clock) reset |=> empty)
      else $error("result present right after reset");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("stalled result beat changed");

   a_lead_byte : assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.run_last) |-> (rsp_data.out_byte[7:5] == 3'b110))
      else $error("non-final beat is not a two-byte lead");

   a_cont_follows : assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_data.run_last) |=>
      (!empty && rsp_data.run_last && rsp_data.out_byte[7:6] == 2'b10))
      else $error("continuation beat missing after lead beat");

endmodule

bind byte_level_text_codec blc_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

`default_nettype wire
